### rtl/assert_macros.svh
// Assertion macros used by the level meter top level.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define SLM_ASSERT_NEVER(label, cond, msg) \
  `SLM_ASSERT(label, !(cond), msg)

`endif

### rtl/slm_pkg.sv
// Shared types and constants for the stereo level meter.
// No dependencies; every RTL module imports this package.
package slm_pkg;

  localparam int SAMPLE_W          = 24;
  localparam int MAG_W             = SAMPLE_W;
  localparam int SQ_W              = 2 * MAG_W - 1;
  localparam int SUM_W             = 60;
  localparam int CNT_W             = 14;
  localparam int CLIP_W            = 23;
  localparam int ROOT_W            = 24;
  localparam int SLOT_W            = 2;
  localparam int SLOT_COUNT        = 3;
  localparam int MAX_BLOCK_SAMPLES = 4096;
  localparam int BLOCK_LIMIT       = 2 * MAX_BLOCK_SAMPLES;

  // Iterative divide then square-root unit.
  localparam int STEP_W      = 6;
  localparam int DIV_STEPS   = SUM_W;
  localparam int ROOT_STEPS  = ROOT_W;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int SREM_W      = ROOT_W + 1;

  // Input beat layout.
  localparam int CMD_W       = 2;
  localparam int CMD_LSB     = 0;
  localparam int STAGE_LSB   = CMD_LSB + CMD_W;
  localparam int SAMPLE_LSB  = STAGE_LSB + SLOT_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CLIP_W-1:0] CLIP_RESET = CLIP_W'(4194304);

  localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [1:0] {
    OP_ACCUM,
    OP_CLOSE,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    kind;
    logic [SLOT_W-1:0]           slot;
    logic                        slot_ok;
    logic signed [SAMPLE_W-1:0]  sample;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]  clips;
    logic [ROOT_W-1:0] rms;
    logic [MAG_W-1:0]  peak;
  } level_t;

  typedef struct packed {
    level_t            lv;
    logic [SLOT_W-1:0] slot;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } rm_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } rm_rsp_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_ROOT,
    BK_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    RM_IDLE,
    RM_DIV,
    RM_ROOT,
    RM_DONE
  } rm_state_t;

endpackage

### rtl/slm_front.sv
// Front end of the level meter: unpacks input beats and classifies them.
// Depends on slm_pkg. Feeds the command queue.
module slm_front (
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [slm_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             push_valid,
  input  logic                             push_ready,
  output slm_pkg::op_t                     push_op
);
  import slm_pkg::*;

  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] stage;
  logic              stage_ok;
  logic              keep;

  assign cmd      = in_tdata[CMD_LSB +: CMD_W];
  assign stage    = in_tdata[STAGE_LSB +: SLOT_W];
  assign stage_ok = (32'(stage) < SLOT_COUNT);

  // Every beat is taken when the queue has room; beats without any effect
  // (unused command, read of a missing slot) are dropped here.
  assign in_tready = push_ready;

  always_comb begin
    push_op.slot    = stage;
    push_op.slot_ok = stage_ok;
    push_op.sample  = in_tdata[SAMPLE_LSB +: SAMPLE_W];
    push_op.kind    = OP_ACCUM;
    keep            = 1'b0;
    case (cmd)
      CMD_ACCUM: begin
        push_op.kind = OP_ACCUM;
        keep         = 1'b1;
      end
      CMD_CLOSE: begin
        push_op.kind = OP_CLOSE;
        keep         = 1'b1;
      end
      CMD_READ: begin
        push_op.kind = OP_READ;
        keep         = stage_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_valid = in_tvalid && keep;

endmodule

### rtl/slm_fifo.sv
// Short command queue between the front end and the back end.
// Depends on slm_pkg for the op type and depth.
module slm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  slm_pkg::op_t  push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output slm_pkg::op_t  pop_op
);
  import slm_pkg::*;

  op_t                entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - FIFO_CW'(1);
      end
    end
  end

endmodule

### rtl/slm_rootmean.sv
// Iterative unit that computes floor(sqrt(floor(sum / count))).
// Depends on slm_pkg. One quotient bit, then one root bit, per cycle.
module slm_rootmean (
  input  logic             clk,
  input  logic             rst_n,
  input  slm_pkg::rm_req_t req,
  output slm_pkg::rm_rsp_t rsp
);
  import slm_pkg::*;

  rm_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  cnt_r;
  logic [CNT_W-1:0]   div_r;
  logic [CNT_W-1:0]   rem_r;
  logic [SUM_W-1:0]   q_r;
  logic [SREM_W-1:0]  srem_r;
  logic [ROOT_W-1:0]  root_r;

  logic [CNT_W:0]     dtrial;
  logic [CNT_W:0]     ddiff;
  logic               dge;
  logic [SREM_W+1:0]  scur;
  logic [SREM_W+1:0]  strial;
  logic [SREM_W+1:0]  sdiff;
  logic               sge;
  logic               last_div;
  logic               last_root;

  // Restoring divide: the dividend leaves q_r at the top while quotient bits
  // enter at the bottom. The remainder always stays below the divisor.
  assign dtrial = {rem_r, q_r[SUM_W-1]};
  assign dge    = (dtrial >= {1'b0, div_r});
  assign ddiff  = dtrial - {1'b0, div_r};

  // Digit-by-digit square root over the low RAD_W quotient bits; the mean
  // square never exceeds the largest single square, so the upper bits are zero.
  assign scur   = {srem_r, q_r[RAD_W-1 -: 2]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sge    = (scur >= strial);
  assign sdiff  = scur - strial;

  assign last_div  = (cnt_r == STEP_W'(DIV_STEPS - 1));
  assign last_root = (cnt_r == STEP_W'(ROOT_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      RM_IDLE: begin
        if (req.start) begin
          state_nxt = RM_DIV;
        end
      end
      RM_DIV: begin
        if (last_div) begin
          state_nxt = RM_ROOT;
        end
      end
      RM_ROOT: begin
        if (last_root) begin
          state_nxt = RM_DONE;
        end
      end
      RM_DONE: begin
        state_nxt = RM_IDLE;
      end
      default: begin
        state_nxt = RM_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.busy = (state_r != RM_IDLE);
    rsp.done = (state_r == RM_DONE);
    rsp.root = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      RM_IDLE: begin
        q_r   <= req.sum;
        div_r <= req.count;
        rem_r <= '0;
        cnt_r <= '0;
      end
      RM_DIV: begin
        rem_r <= dge ? ddiff[CNT_W-1:0] : dtrial[CNT_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], dge};
        if (last_div) begin
          cnt_r  <= '0;
          srem_r <= '0;
          root_r <= '0;
        end else begin
          cnt_r <= cnt_r + STEP_W'(1);
        end
      end
      RM_ROOT: begin
        srem_r <= sge ? sdiff[SREM_W-1:0] : scur[SREM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], sge};
        q_r    <= {q_r[SUM_W-3:0], 2'b00};
        cnt_r  <= cnt_r + STEP_W'(1);
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

### rtl/slm_back.sv
// Back end of the level meter: accumulators, close sequencing, stage slots
// and the output register. Depends on slm_pkg and slm_rootmean.
module slm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [slm_pkg::CLIP_W-1:0]   clip_level,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  slm_pkg::op_t                 pop_op,
  output slm_pkg::rm_req_t             rm_req,
  input  slm_pkg::rm_rsp_t             rm_rsp,
  output logic                         out_valid,
  input  logic                         out_ready,
  output slm_pkg::result_t             out_result
);
  import slm_pkg::*;

  back_state_t        state_r, state_nxt;

  logic [MAG_W-1:0]   peak_r, peak_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic [CNT_W-1:0]   clips_r, clips_nxt;

  logic               v1_r;
  logic [MAG_W-1:0]   mag_r;
  logic               v2_r;
  logic [SQ_W-1:0]    sq_r;
  logic [2*MAG_W-1:0] prod;

  logic [MAG_W-1:0]   cl_peak_r;
  logic [CNT_W-1:0]   cl_clips_r;
  logic [SLOT_W-1:0]  cl_slot_r;
  logic [ROOT_W-1:0]  rms_r;

  level_t             lv_r [SLOT_COUNT];
  logic               out_valid_r;
  result_t            out_data_r;

  logic [SAMPLE_W-1:0] raw;
  logic [MAG_W-1:0]   mag;
  logic               out_free;
  logic               acc_take;
  logic               acc_ok;
  logic               close_take;
  logic               read_take;
  logic               emit_load;
  level_t             emit_lv;

  assign raw      = pop_op.sample;
  assign mag      = raw[SAMPLE_W-1] ? (~raw + MAG_W'(1)) : raw;
  assign out_free = !out_valid_r || out_ready;
  assign prod     = mag_r * mag_r;

  assign emit_lv.peak  = cl_peak_r;
  assign emit_lv.rms   = rms_r;
  assign emit_lv.clips = cl_clips_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_RUN: begin
        if (close_take && pop_op.slot_ok) begin
          state_nxt = (seen_r == '0) ? BK_EMIT : BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (rm_rsp.done) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  // Outputs of the sequencer. A close waits for the square pipeline to
  // drain so that the sum it hands over is final.
  always_comb begin
    pop_ready = 1'b0;
    if (state_r == BK_RUN && pop_valid) begin
      case (pop_op.kind)
        OP_ACCUM: pop_ready = 1'b1;
        OP_CLOSE: pop_ready = !v1_r && !v2_r;
        OP_READ:  pop_ready = out_free;
        default:  pop_ready = 1'b0;
      endcase
    end
    acc_take     = pop_ready && (pop_op.kind == OP_ACCUM);
    close_take   = pop_ready && (pop_op.kind == OP_CLOSE);
    read_take    = pop_ready && (pop_op.kind == OP_READ);
    acc_ok       = acc_take && (seen_r < CNT_W'(BLOCK_LIMIT));
    emit_load    = (state_r == BK_EMIT) && out_free;
    rm_req.start = close_take && pop_op.slot_ok && (seen_r != '0);
    rm_req.sum   = sum_r;
    rm_req.count = seen_r;
  end

  // Accumulator updates.
  always_comb begin
    peak_nxt  = peak_r;
    sum_nxt   = sum_r;
    seen_nxt  = seen_r;
    clips_nxt = clips_r;
    if (close_take) begin
      peak_nxt  = '0;
      sum_nxt   = '0;
      seen_nxt  = '0;
      clips_nxt = '0;
    end else begin
      if (acc_ok) begin
        if (mag > peak_r) begin
          peak_nxt = mag;
        end
        if (mag > MAG_W'(clip_level)) begin
          clips_nxt = clips_r + CNT_W'(1);
        end
        seen_nxt = seen_r + CNT_W'(1);
      end
      if (v2_r) begin
        sum_nxt = sum_r + SUM_W'(sq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      peak_r      <= '0;
      sum_r       <= '0;
      seen_r      <= '0;
      clips_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        lv_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      peak_r  <= peak_nxt;
      sum_r   <= sum_nxt;
      seen_r  <= seen_nxt;
      clips_r <= clips_nxt;
      v1_r    <= acc_ok;
      v2_r    <= v1_r;
      if (read_take || emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_load) begin
        lv_r[cl_slot_r] <= emit_lv;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag;
    sq_r  <= prod[SQ_W-1:0];
    if (close_take) begin
      cl_peak_r  <= peak_r;
      cl_clips_r <= clips_r;
      cl_slot_r  <= pop_op.slot;
      rms_r      <= '0;
    end else if (state_r == BK_ROOT && rm_rsp.done) begin
      rms_r <= rm_rsp.root;
    end
    if (read_take) begin
      out_data_r.lv   <= lv_r[pop_op.slot];
      out_data_r.slot <= pop_op.slot;
    end else if (emit_load) begin
      out_data_r.lv   <= emit_lv;
      out_data_r.slot <= cl_slot_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

endmodule

### rtl/stereo_level_meter_top.sv
// Top level of the stereo level meter: ports, clip threshold and assertions.
// Depends on slm_pkg, assert_macros.svh and the slm_* submodules.

// Stereo block level meter. Send the samples of one audio block (left channel,
// then right channel) as accumulate beats, then one close beat naming a stage
// slot; the block answers the close with the block's peak magnitude, floor rms
// and clip count, and keeps them in that slot for later read beats. Accumulate
// beats are taken one per cycle while the queue has room and produce no result;
// beyond 8192 samples in one block they are ignored until the close. A close
// first waits for the two stage squaring pipeline to drain, then runs a shared
// iterative unit that divides the sum of squares by the sample count one
// quotient bit per cycle and takes the square root one result bit per cycle.
// A close of an empty block skips the unit and goes straight to the emit state,
// and a close naming a missing slot only clears the block. A read is answered
// from the slot record through the output register. A four-beat queue sits
// between the input port and the back end, so the next samples are taken while
// a close is still being worked out. clip_level may be written only while the
// block is idle.
`include "assert_macros.svh"

module stereo_level_meter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // Clip threshold write.
  input  logic                             cfg_wr_en,
  input  logic [slm_pkg::CLIP_W-1:0]       cfg_wr_data,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata from bit 0: command[1:0], stage[3:2], sample[27:4], zero pad[31:28].
  input  logic [slm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata from bit 0: slot[1:0], peak_level[25:2], rms_level[49:26],
  // clip_total[63:50].
  output logic [slm_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import slm_pkg::*;

  logic [CLIP_W-1:0] clip_level_r;

  logic    push_valid;
  logic    push_ready;
  op_t     push_op;
  logic    pop_valid;
  logic    pop_ready;
  op_t     pop_op;
  rm_req_t rm_req;
  rm_rsp_t rm_rsp;
  result_t out_result;

  // The threshold register takes a write on every beat of the write enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_level_r <= CLIP_RESET;
    end else if (cfg_wr_en) begin
      clip_level_r <= cfg_wr_data;
    end
  end

  slm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  slm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  slm_rootmean u_rootmean (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rm_req),
    .rsp   (rm_rsp)
  );

  slm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clip_level (clip_level_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op),
    .rm_req     (rm_req),
    .rm_rsp     (rm_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = out_result;

  // The back end never starts a root computation while one is running.
  `SLM_ASSERT_NEVER(a_start_while_busy, rm_req.start && rm_rsp.busy, "root unit restarted while busy")
  // A start always puts the root unit to work on the next cycle.
  `SLM_ASSERT(a_start_takes, rm_req.start |=> rm_rsp.busy, "root unit ignored a start")
  // The input side only stalls when the queue holds work for the back end.
  `SLM_ASSERT(a_stall_has_work, !in_tready |-> pop_valid, "input stalled with an empty queue")

endmodule

### dv/tb_stereo_level_meter_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_level_meter_top: streams sample, close and read beats
// and checks each result beat against a scoreboard that predicts the level meter.
// Depends on slm_pkg and the stereo level meter RTL; needs no files or arguments.

module tb_stereo_level_meter_top;
  import slm_pkg::*;

  // The command encoding leaves value 3 unused, and stage 3 names no slot.
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [SLOT_W-1:0] SLOT_RAW   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_IN    = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_OUT   = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_BAD   = 2'd3;

  localparam logic [SAMPLE_W-1:0] FULL_POS = 24'h7fffff;
  localparam logic [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

  // A close can occupy the divide and root unit, and up to four beats sit in the
  // input queue, so this covers closes that name no slot and therefore produce
  // nothing we could wait for.
  localparam int SETTLE_CYCLES = 500;
  // This leaves a wide margin over the slowest correct run.
  localparam int CYCLE_LIMIT   = 600000;

  // Predicts the meter: open block accumulators, the three slot records and the
  // clip threshold, plus the queue of result beats still owed by the block.
  class level_scoreboard;
    logic [CLIP_W-1:0] clip_level;
    logic [MAG_W-1:0]  open_peak;
    logic [63:0]       open_sum;
    logic [CNT_W-1:0]  open_count;
    logic [CNT_W-1:0]  open_clips;
    level_t            slot_levels [SLOT_COUNT];
    result_t           owed_levels [$];
    int                errors;

    function new();
      clip_level = CLIP_RESET;
      clear_block();
      foreach (slot_levels[i]) slot_levels[i] = '0;
      errors = 0;
    endfunction

    function void clear_block();
      open_peak  = '0;
      open_sum   = '0;
      open_count = '0;
      open_clips = '0;
    endfunction

    // Floor square root, built one result bit at a time from the top.
    function logic [ROOT_W-1:0] floor_root(logic [63:0] radicand);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= radicand) root = trial;
      end
      return root[ROOT_W-1:0];
    endfunction

    function void owe_slot(logic [SLOT_W-1:0] slot);
      result_t r;
      r.lv   = slot_levels[slot];
      r.slot = slot;
      owed_levels.push_back(r);
    endfunction

    // Called for every accepted input beat.
    function void note_beat(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] stage,
                            logic [SAMPLE_W-1:0] sample);
      logic [MAG_W-1:0] mag;
      logic [63:0]      square;
      level_t           lv;
      case (cmd)
        CMD_ACCUM: begin
          mag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
          // A full block ignores further samples until it is closed.
          if (open_count < BLOCK_LIMIT) begin
            if (mag > open_peak) open_peak = mag;
            square   = 64'(mag) * 64'(mag);
            open_sum = (open_sum > ~square) ? '1 : open_sum + square;
            if (mag > clip_level) open_clips++;
            open_count++;
          end
        end
        CMD_CLOSE: begin
          lv.peak  = open_peak;
          lv.clips = open_clips;
          lv.rms   = (open_count != 0) ? floor_root(open_sum / open_count) : '0;
          clear_block();
          // A close naming no slot only drops the open block.
          if (stage < SLOT_COUNT) begin
            slot_levels[stage] = lv;
            owe_slot(stage);
          end
        end
        CMD_READ: begin
          if (stage < SLOT_COUNT) owe_slot(stage);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result beat.
    function void check_result(result_t got);
      result_t want;
      if (owed_levels.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = owed_levels.pop_front();
      compare_field("slot", want.slot, got.slot);
      compare_field("peak_level", want.lv.peak, got.lv.peak);
      compare_field("rms_level", want.lv.rms, got.lv.rms);
      compare_field("clip_total", want.lv.clips, got.lv.clips);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CLIP_W-1:0]      cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  // tdata from bit 0: command[1:0], stage[3:2], sample[27:4], zero pad[31:28].
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // tdata from bit 0: slot[1:0], peak_level[25:2], rms_level[49:26], clip_total[63:50].
  logic [OUT_TDATA_W-1:0] out_tdata;

  level_scoreboard board = new();
  bit              idle_on;
  int unsigned     items_sent;
  int unsigned     cycle_count;

  stereo_level_meter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Both channels are sampled at the clock edge, before any of this edge's
  // nonblocking updates land, so the monitor sees exactly what the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        board.note_beat(in_tdata[1:0], in_tdata[3:2], in_tdata[27:4]);
      if (out_tvalid && out_tready)
        board.check_result(result_t'(out_tdata));
    end
  end

  // The result side drops tready in random bursts while idling is enabled.
  initial begin : ready_pattern
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Presents one beat and returns at the edge that accepts it. tvalid stays high
  // afterwards, so back-to-back beats need no extra assignment to it.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] stage,
                           input logic [SAMPLE_W-1:0] sample);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, sample, stage, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Stops sending, waits for every owed result and then lets the back end settle,
  // so the block is idle when this returns.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle; the threshold applies from the next beat.
  task automatic write_clip(input logic [CLIP_W-1:0] level);
    cfg_wr_data <= level;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.clip_level = level;
  endtask

  // Samples mix full-range noise, values close to the clip threshold, the
  // extremes and quiet material.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned pick;
    int          mag;
    pick = $urandom_range(0, 9);
    if (pick < 4) return SAMPLE_W'($urandom);
    if (pick < 6) begin
      mag = int'(board.clip_level) - 2 + int'($urandom_range(0, 4));
      if (mag < 0) mag = 0;
      if (mag > 8388608) mag = 8388608;
      return $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    end
    if (pick < 7) begin
      case ($urandom_range(0, 3))
        0:       return FULL_POS;
        1:       return FULL_NEG;
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
  endfunction

  // Mostly well-formed blocks of random length closed into a random slot, with
  // reads, closes into no slot and unused commands mixed in.
  task automatic run_traffic(input int unsigned item_goal);
    int unsigned goal_end;
    int unsigned pick;
    int unsigned len;
    goal_end = items_sent + item_goal;
    while (items_sent < goal_end) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 12);
        repeat (len) send_beat(CMD_ACCUM, SLOT_W'($urandom), pick_sample());
        send_beat(CMD_CLOSE,
                  ($urandom_range(0, 9) == 0) ? SLOT_BAD : SLOT_W'($urandom_range(0, 2)),
                  SAMPLE_W'($urandom));
      end else if (pick < 90) begin
        send_beat(CMD_READ, SLOT_W'($urandom_range(0, 3)), SAMPLE_W'($urandom));
      end else begin
        send_beat(CMD_UNUSED, SLOT_W'($urandom), SAMPLE_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cycle_count <= 0;
    items_sent  = 0;
    idle_on     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset threshold of half full scale.
    send_beat(CMD_READ, SLOT_IN, '0);        // slots read as zero after reset
    send_beat(CMD_READ, SLOT_BAD, '1);       // a read of no slot gives nothing
    send_beat(CMD_CLOSE, SLOT_OUT, '0);      // an empty block closes to all zeros
    send_beat(CMD_ACCUM, SLOT_RAW, FULL_POS);
    send_beat(CMD_ACCUM, SLOT_BAD, FULL_NEG); // largest magnitude, one past full range
    send_beat(CMD_ACCUM, SLOT_RAW, '0);
    send_beat(CMD_ACCUM, SLOT_RAW, '1);
    send_beat(CMD_ACCUM, SLOT_RAW, 24'd1);
    send_beat(CMD_ACCUM, SLOT_RAW, 24'd4194304);  // exactly at the threshold: not clipped
    send_beat(CMD_ACCUM, SLOT_RAW, 24'd4194305);  // one above: clipped
    send_beat(CMD_ACCUM, SLOT_RAW, -24'sd4194305);
    send_beat(CMD_UNUSED, SLOT_BAD, '1);     // unused command leaves everything alone
    send_beat(CMD_CLOSE, SLOT_RAW, '0);
    send_beat(CMD_READ, SLOT_RAW, '0);
    send_beat(CMD_READ, SLOT_OUT, '0);
    send_beat(CMD_ACCUM, SLOT_IN, 24'd12345);
    send_beat(CMD_CLOSE, SLOT_BAD, '1);      // drops the block without a result
    send_beat(CMD_CLOSE, SLOT_IN, '0);       // so this close sees an empty block
    send_beat(CMD_READ, SLOT_IN, '0);
    send_beat(CMD_READ, SLOT_RAW, '1);
    send_beat(CMD_UNUSED, SLOT_RAW, '0);
    wait_drained();

    // Threshold at zero: every nonzero sample clips.
    idle_on = 1'b1;
    write_clip('0);
    run_traffic(180);
    wait_drained();

    // Threshold at its top: only the most negative sample clips.
    write_clip('1);
    run_traffic(180);
    wait_drained();

    // A random threshold.
    write_clip(CLIP_W'($urandom));
    run_traffic(200);
    wait_drained();

    // A phase without idling on either side, just below half of full scale.
    idle_on = 1'b0;
    write_clip(CLIP_W'(4194303));
    run_traffic(220);
    wait_drained();

    idle_on = 1'b1;
    write_clip(CLIP_W'($urandom_range(0, 8388607)));
    run_traffic(200);
    wait_drained();

    // The closing stretch runs at full rate with the reset threshold back in place.
    idle_on = 1'b0;
    write_clip(CLIP_RESET);
    run_traffic(150);
    wait_drained();

    if (board.errors == 0 && board.owed_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/slm_pkg.sv
rtl/slm_front.sv
rtl/slm_fifo.sv
rtl/slm_rootmean.sv
rtl/slm_back.sv
rtl/stereo_level_meter_top.sv
dv/tb_stereo_level_meter_top.sv
